/* rtl/hpq_pkg.sv */
`timescale 1ns / 1ps
package hpq_pkg;

  localparam int DATA_W       = 32;
  localparam int CNT_W        = 11;
  localparam int CAPACITY_DEF = 1024;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_MIN    = 2'd1;
  localparam logic [1:0] REQ_MAX    = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // children then grandchildren of position p: (p << DESC_SHIFT) + DESC_ADD
  localparam int NUM_DESC = 6;
  localparam logic [1:0] DESC_SHIFT [0:NUM_DESC-1] = '{2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2};
  localparam logic [1:0] DESC_ADD   [0:NUM_DESC-1] = '{2'd0, 2'd1, 2'd0, 2'd1, 2'd2, 2'd3};

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [DATA_W-1:0] value;
  } hpq_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic [1:0]               status;
    logic [CNT_W-1:0]         entry_count;
  } hpq_rsp_t;

endpackage

/* rtl/hpq_mem.sv */
`timescale 1ns / 1ps
module hpq_mem
  import hpq_pkg::*;
#(
  parameter int DEPTH = CAPACITY_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/min_max_heap_priority_queue.sv */
`timescale 1ns / 1ps
// Double-ended priority queue on a min-max heap of signed 32-bit values.
// Command channel: drive cmd and raise start; the transaction is taken at a
// rising edge where start is high and busy is low. busy stays high until the
// result has been shown. Result channel: done pulses for exactly one cycle
// with rsp (removed value, status, count after the request); the receiver
// cannot stall it and must take it in that cycle.
// Requests: insert, remove minimum, remove maximum. Empty removal reports
// empty; insert into a full heap reports full and drops the value.
// Errors, unused codes and an insert into an empty heap go straight to the
// result. Other inserts compare with the parent, then bubble up by
// grandparent steps. A removal reads the root or its two children and the
// last entry, then trickles down by grandchild steps, fetching each of the
// six descendants through the single read port of the heap memory. A new
// transaction can be taken in the cycle after done.
// Reset clears the count and control state only; the heap memory is never
// cleared, and only entries below the count are ever used.
module min_max_heap_priority_queue
  import hpq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  hpq_req_t cmd,
  output logic     busy,
  output logic     done,
  output hpq_rsp_t rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int PW = $clog2(CAPACITY + 1);
  localparam int DW = PW + 2;

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_UP_PAR  = 14'b00000000000010,
    S_UP_CHK  = 14'b00000000000100,
    S_UP_GP   = 14'b00000000001000,
    S_RM_ROOT = 14'b00000000010000,
    S_RM_C2   = 14'b00000000100000,
    S_RM_C3   = 14'b00000001000000,
    S_RM_LAST = 14'b00000010000000,
    S_TD_TOP  = 14'b00000100000000,
    S_TD_SCAN = 14'b00001000000000,
    S_TD_DEC  = 14'b00010000000000,
    S_TD_FIX  = 14'b00100000000000,
    S_TD_LAST = 14'b01000000000000,
    S_EMIT    = 14'b10000000000000
  } state_t;

  state_t state, state_next;
  logic [PW-1:0] cnt, cnt_next;
  logic [PW-1:0] pos, pos_next;
  logic [PW-1:0] m, m_next;
  logic [DW-1:0] best, best_next;
  logic [2:0]    k, k_next;
  logic          dirmin, dirmin_next;
  logic signed [DATA_W-1:0] x, x_next;
  logic signed [DATA_W-1:0] bestv, bestv_next;
  logic signed [DATA_W-1:0] ch0, ch0_next;
  logic signed [DATA_W-1:0] ch1, ch1_next;
  logic signed [DATA_W-1:0] res, res_next;
  logic [1:0]    status, status_next;

  logic                     we;
  logic [PW-1:0]            wr_pos;
  logic [PW-1:0]            rd_pos;
  logic signed [DATA_W-1:0] wdata;
  logic signed [DATA_W-1:0] rdata;
  logic [DATA_W-1:0]        rdata_raw;

  logic [DW-1:0]            c_cur;
  logic [DW-1:0]            c_nxt;
  logic [2:0]               k_inc;
  logic signed [DATA_W-1:0] pv;

  function automatic logic odd_level(input logic [PW-1:0] p);
    logic lvl;
    lvl = 1'b0;
    for (int i = 0; i < PW; i++) begin
      if (p[i]) lvl = i[0];
    end
    return lvl;
  endfunction

  function automatic logic [DW-1:0] desc_pos(input logic [PW-1:0] p, input logic [2:0] idx);
    logic [DW-1:0] r;
    r = '0;
    if (idx < 3'(NUM_DESC)) begin
      r = (DW'(p) << DESC_SHIFT[idx]) + DW'(DESC_ADD[idx]);
    end
    return r;
  endfunction

  function automatic logic better(input logic signed [DATA_W-1:0] a,
                                  input logic signed [DATA_W-1:0] b, input logic mn);
    return mn ? (a < b) : (a > b);
  endfunction

  function automatic logic [AW-1:0] to_addr(input logic [PW-1:0] p);
    logic [PW-1:0] t;
    t = p - 1'b1;
    return t[AW-1:0];
  endfunction

  hpq_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (to_addr(wr_pos)),
    .wdata (wdata),
    .raddr (to_addr(rd_pos)),
    .rdata (rdata_raw)
  );

  assign rdata = rdata_raw;
  assign c_cur = desc_pos(pos, k);
  assign k_inc = k + 3'd1;
  assign c_nxt = desc_pos(pos, k_inc);
  assign pv    = best[1] ? ch1 : ch0;

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    pos_next    = pos;
    m_next      = m;
    best_next   = best;
    k_next      = k;
    dirmin_next = dirmin;
    x_next      = x;
    bestv_next  = bestv;
    ch0_next    = ch0;
    ch1_next    = ch1;
    res_next    = res;
    status_next = status;
    we          = 1'b0;
    wr_pos      = pos;
    wdata       = x;
    rd_pos      = pos;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          res_next    = '0;
          status_next = ST_OK;
          case (cmd.req_type)
            REQ_INSERT: begin
              if (cnt == PW'(CAPACITY)) begin
                status_next = ST_FULL;
                state_next  = S_EMIT;
              end else begin
                cnt_next = cnt + 1'b1;
                pos_next = cnt + 1'b1;
                x_next   = cmd.value;
                if (cnt == '0) begin
                  we         = 1'b1;
                  wr_pos     = PW'(1);
                  wdata      = cmd.value;
                  state_next = S_EMIT;
                end else begin
                  rd_pos     = (cnt + 1'b1) >> 1;
                  state_next = S_UP_PAR;
                end
              end
            end
            REQ_MIN, REQ_MAX: begin
              if (cnt == '0) begin
                status_next = ST_EMPTY;
                state_next  = S_EMIT;
              end else if (cmd.req_type == REQ_MIN || cnt == PW'(1)) begin
                rd_pos     = PW'(1);
                m_next     = PW'(1);
                state_next = S_RM_ROOT;
              end else begin
                rd_pos     = PW'(2);
                state_next = S_RM_C2;
              end
            end
            default: state_next = S_EMIT;
          endcase
        end
      end
      S_UP_PAR: begin
        if (odd_level(pos) ? (x < rdata) : (x > rdata)) begin
          we          = 1'b1;
          wdata       = rdata;
          pos_next    = pos >> 1;
          dirmin_next = odd_level(pos);
        end else begin
          dirmin_next = !odd_level(pos);
        end
        state_next = S_UP_CHK;
      end
      S_UP_CHK: begin
        if (pos >= PW'(4)) begin
          rd_pos     = pos >> 2;
          state_next = S_UP_GP;
        end else begin
          we         = 1'b1;
          state_next = S_EMIT;
        end
      end
      S_UP_GP: begin
        we = 1'b1;
        if (better(x, rdata, dirmin)) begin
          wdata      = rdata;
          pos_next   = pos >> 2;
          state_next = S_UP_CHK;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_RM_ROOT: begin
        bestv_next = rdata;
        rd_pos     = cnt;
        state_next = S_RM_LAST;
      end
      S_RM_C2: begin
        bestv_next = rdata;
        m_next     = PW'(2);
        if (cnt >= PW'(3)) begin
          rd_pos     = PW'(3);
          state_next = S_RM_C3;
        end else begin
          rd_pos     = cnt;
          state_next = S_RM_LAST;
        end
      end
      S_RM_C3: begin
        if (rdata > bestv) begin
          bestv_next = rdata;
          m_next     = PW'(3);
        end
        rd_pos     = cnt;
        state_next = S_RM_LAST;
      end
      S_RM_LAST: begin
        // last entry fills the hole left by the removed one
        x_next      = rdata;
        cnt_next    = cnt - 1'b1;
        res_next    = bestv;
        pos_next    = m;
        dirmin_next = !odd_level(m);
        state_next  = (m < cnt) ? S_TD_TOP : S_EMIT;
      end
      S_TD_TOP: begin
        if ((DW'(pos) << 1) <= DW'(cnt)) begin
          rd_pos     = pos << 1;
          k_next     = '0;
          best_next  = DW'(pos) << 1;
          state_next = S_TD_SCAN;
        end else begin
          we         = 1'b1;
          state_next = S_EMIT;
        end
      end
      S_TD_SCAN: begin
        if (k == '0) begin
          bestv_next = rdata;
          best_next  = c_cur;
          ch0_next   = rdata;
        end else if (better(rdata, bestv, dirmin)) begin
          bestv_next = rdata;
          best_next  = c_cur;
        end
        if (k == 3'd1) begin
          ch1_next = rdata;
        end
        if (k_inc < 3'(NUM_DESC) && c_nxt <= DW'(cnt)) begin
          rd_pos = c_nxt[PW-1:0];
          k_next = k_inc;
        end else begin
          state_next = S_TD_DEC;
        end
      end
      S_TD_DEC: begin
        we = 1'b1;
        if (best >= (DW'(pos) << 2)) begin
          if (better(bestv, x, dirmin)) begin
            wdata    = bestv;
            pos_next = best[PW-1:0];
            if (dirmin ? (x > pv) : (x < pv)) begin
              state_next = S_TD_FIX;
            end else begin
              state_next = S_TD_TOP;
            end
          end else begin
            state_next = S_EMIT;
          end
        end else if (better(bestv, x, dirmin)) begin
          wdata      = bestv;
          state_next = S_TD_LAST;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_TD_FIX: begin
        // moved value takes the parent's place; parent value carries on down
        we         = 1'b1;
        wr_pos     = pos >> 1;
        x_next     = pv;
        state_next = S_TD_TOP;
      end
      S_TD_LAST: begin
        we         = 1'b1;
        wr_pos     = best[PW-1:0];
        state_next = S_EMIT;
      end
      S_EMIT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    pos    <= pos_next;
    m      <= m_next;
    best   <= best_next;
    k      <= k_next;
    dirmin <= dirmin_next;
    x      <= x_next;
    bestv  <= bestv_next;
    ch0    <= ch0_next;
    ch1    <= ch1_next;
    res    <= res_next;
    status <= status_next;
  end

  assign busy             = (state != S_IDLE);
  assign done             = (state == S_EMIT);
  assign rsp.result_value = res;
  assign rsp.status       = status;
  assign rsp.entry_count  = CNT_W'(cnt);

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= PW'(CAPACITY))
    else $error("count exceeds capacity");
  a_full_cnt: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_FULL |-> cnt == PW'(CAPACITY))
    else $error("full reported below capacity");
  a_empty_cnt: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_EMPTY |-> cnt == '0)
    else $error("empty reported with entries held");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");
`endif

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import hpq_pkg::*;

  localparam int HEAP_CAP = CAPACITY_DEF;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  hpq_req_t cmd = '0;
  logic     busy;
  logic     done;
  hpq_rsp_t rsp;

  min_max_heap_priority_queue #(.CAPACITY(HEAP_CAP)) dut (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd),
    .busy(busy), .done(done), .rsp(rsp)
  );

  always #2 clk = ~clk;

  // predictor state: keys kept as signed values, positions from 1
  logic signed [DATA_W-1:0] heap_keys [1:HEAP_CAP];
  int unsigned heap_fill;
  hpq_rsp_t rsp_queue [$];
  int errors = 0;
  int n_sent = 0, n_checked = 0, n_full = 0, n_empty = 0;

  function automatic bit is_min_level(int unsigned pos);
    int unsigned lvl;
    lvl = 0;
    while (pos > 1) begin
      pos >>= 1;
      lvl++;
    end
    return (lvl & 1) == 0;
  endfunction

  function automatic bit beats(logic signed [DATA_W-1:0] a, logic signed [DATA_W-1:0] b,
                               bit min_side);
    return min_side ? (a < b) : (a > b);
  endfunction

  function automatic void swap_keys(int unsigned a, int unsigned b);
    logic signed [DATA_W-1:0] t;
    t = heap_keys[a];
    heap_keys[a] = heap_keys[b];
    heap_keys[b] = t;
  endfunction

  function automatic void rise_by_gp(int unsigned pos, bit min_side);
    while (pos / 4 >= 1) begin
      if (!beats(heap_keys[pos], heap_keys[pos/4], min_side)) break;
      swap_keys(pos, pos / 4);
      pos = pos / 4;
    end
  endfunction

  function automatic void sift_up(int unsigned pos);
    bit mn;
    if (pos <= 1) return;
    mn = is_min_level(pos);
    if (beats(heap_keys[pos/2], heap_keys[pos], mn)) begin
      swap_keys(pos, pos / 2);
      rise_by_gp(pos / 2, !mn);
    end else begin
      rise_by_gp(pos, mn);
    end
  endfunction

  function automatic void sift_down(int unsigned pos);
    bit mn;
    int unsigned best, c;
    mn = is_min_level(pos);
    while (2 * pos <= heap_fill) begin
      best = 2 * pos;
      for (int k = 1; k < NUM_DESC; k++) begin
        c = (pos << DESC_SHIFT[k]) + DESC_ADD[k];
        if (c > heap_fill) break;
        if (beats(heap_keys[c], heap_keys[best], mn)) best = c;
      end
      if (best >= 4 * pos) begin
        if (!beats(heap_keys[best], heap_keys[pos], mn)) break;
        swap_keys(best, pos);
        if (beats(heap_keys[best/2], heap_keys[best], mn)) swap_keys(best, best / 2);
        pos = best;
      end else begin
        if (beats(heap_keys[best], heap_keys[pos], mn)) swap_keys(best, pos);
        break;
      end
    end
  endfunction

  function automatic logic signed [DATA_W-1:0] take_out(int unsigned pos);
    logic signed [DATA_W-1:0] v;
    v = heap_keys[pos];
    heap_keys[pos] = heap_keys[heap_fill];
    heap_fill--;
    if (pos <= heap_fill) sift_down(pos);
    return v;
  endfunction

  function automatic hpq_rsp_t predict_queue_op(hpq_req_t r);
    hpq_rsp_t o;
    int unsigned m;
    o = '0;
    o.status = ST_OK;
    if (r.req_type == REQ_INSERT) begin
      if (heap_fill >= HEAP_CAP) begin
        o.status = ST_FULL;
      end else begin
        heap_fill++;
        heap_keys[heap_fill] = r.value;
        sift_up(heap_fill);
      end
    end else if (r.req_type == REQ_MIN || r.req_type == REQ_MAX) begin
      if (heap_fill == 0) begin
        o.status = ST_EMPTY;
      end else if (r.req_type == REQ_MIN || heap_fill == 1) begin
        o.result_value = take_out(1);
      end else begin
        m = 2;
        if (heap_fill >= 3 && heap_keys[3] > heap_keys[2]) m = 3;
        o.result_value = take_out(m);
      end
    end
    o.entry_count = heap_fill[CNT_W-1:0];
    return o;
  endfunction

  // results: compare with the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (rsp_queue.size() == 0) begin
        $display("%0t: unexpected result %p", $time, rsp);
        errors++;
      end else begin
        hpq_rsp_t e;
        e = rsp_queue.pop_front();
        n_checked++;
        if (rsp.result_value !== e.result_value)
          $display("%0t: result_value expected %0d actual %0d", $time,
                   e.result_value, rsp.result_value);
        if (rsp.status !== e.status)
          $display("%0t: status expected %0d actual %0d", $time, e.status, rsp.status);
        if (rsp.entry_count !== e.entry_count)
          $display("%0t: entry_count expected %0d actual %0d", $time,
                   e.entry_count, rsp.entry_count);
        if (rsp !== e) errors++;
      end
    end
  end

  int burst_left = 0;

  // present one transaction, hold until taken, with random gaps between bursts
  task automatic issue(hpq_req_t r, bit has_fixed, hpq_rsp_t fixed);
    hpq_rsp_t p;
    if (burst_left == 0) begin
      if ($urandom_range(3) != 0) repeat ($urandom_range(12)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    @(negedge clk);
    start <= 1'b1;
    cmd <= r;
    do @(posedge clk); while (busy);
    p = predict_queue_op(r);
    if (has_fixed && p !== fixed) begin
      $display("%0t: directed row expected %p predicted %p", $time, fixed, p);
      errors++;
    end
    rsp_queue.push_back(p);
    n_sent++;
    if (p.status == ST_FULL) n_full++;
    if (p.status == ST_EMPTY) n_empty++;
    @(negedge clk);
    start <= 1'b0;
  endtask

  function automatic logic signed [DATA_W-1:0] rand_value();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(8)) - 4;
      default: return $signed($urandom());
    endcase
  endfunction

  typedef struct {
    logic [1:0]               req;
    logic signed [DATA_W-1:0] val;
    bit                       fixed;
    logic signed [DATA_W-1:0] exp_val;
    logic [1:0]               exp_st;
    int                       exp_cnt;
  } dir_row_t;

  dir_row_t dir_rows [] = '{
    '{REQ_MIN,    32'sd0,          1, 32'sd0,          ST_EMPTY, 0},
    '{REQ_MAX,    32'sd5,          1, 32'sd0,          ST_EMPTY, 0},
    '{REQ_UNUSED, 32'sd7,          1, 32'sd0,          ST_OK,    0},
    '{REQ_INSERT, 32'sh7fffffff,   1, 32'sd0,          ST_OK,    1},
    '{REQ_MAX,    32'sd0,          1, 32'sh7fffffff,   ST_OK,    0},
    '{REQ_INSERT, 32'sh80000000,   1, 32'sd0,          ST_OK,    1},
    '{REQ_MIN,    32'sd0,          1, 32'sh80000000,   ST_OK,    0},
    '{REQ_INSERT, -32'sd1,         1, 32'sd0,          ST_OK,    1},
    '{REQ_INSERT, 32'sd9,          1, 32'sd0,          ST_OK,    2},
    '{REQ_INSERT, 32'sd9,          1, 32'sd0,          ST_OK,    3},
    '{REQ_MAX,    32'sd0,          1, 32'sd9,          ST_OK,    2},
    '{REQ_INSERT, 32'sh7fffffff,   0, 0, 0, 0},
    '{REQ_INSERT, 32'sh80000000,   0, 0, 0, 0},
    '{REQ_INSERT, 32'sd3,          0, 0, 0, 0},
    '{REQ_INSERT, -32'sd3,         0, 0, 0, 0},
    '{REQ_UNUSED, -32'sd1,         0, 0, 0, 0},
    '{REQ_MAX,    32'sd0,          0, 0, 0, 0},
    '{REQ_MIN,    32'sd0,          0, 0, 0, 0},
    '{REQ_MAX,    32'sd0,          0, 0, 0, 0},
    '{REQ_MIN,    32'sd0,          0, 0, 0, 0},
    '{REQ_MIN,    32'sd0,          0, 0, 0, 0},
    '{REQ_MIN,    32'sd0,          0, 0, 0, 0},
    '{REQ_MIN,    32'sd0,          0, 0, 0, 0}
  };

  initial begin
    hpq_req_t r;
    hpq_rsp_t f;
    int bias;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    heap_fill = 0;
    foreach (dir_rows[i]) begin
      r.req_type = dir_rows[i].req;
      r.value = dir_rows[i].val;
      f.result_value = dir_rows[i].exp_val;
      f.status = dir_rows[i].exp_st;
      f.entry_count = dir_rows[i].exp_cnt[CNT_W-1:0];
      issue(r, dir_rows[i].fixed, f);
    end
    // random phases: mixed, fill-biased, drain-biased
    for (int i = 0; i < 380; i++) begin
      bias = (i / 75) % 3;
      case ($urandom_range(19))
        0: r.req_type = REQ_UNUSED;
        1, 2, 3, 4, 5, 6: r.req_type = (bias == 2) ? REQ_MIN : REQ_INSERT;
        7, 8, 9, 10, 11, 12: r.req_type = (bias == 1) ? REQ_INSERT : REQ_MAX;
        default: r.req_type = ($urandom_range(1) != 0) ? REQ_INSERT :
                              (($urandom_range(1) != 0) ? REQ_MIN : REQ_MAX);
      endcase
      r.value = rand_value();
      issue(r, 0, '0);
    end
    // drain past empty
    while (heap_fill > 0) begin
      r.req_type = ($urandom_range(1) != 0) ? REQ_MIN : REQ_MAX;
      issue(r, 0, '0);
    end
    r.req_type = REQ_MAX;
    f = '{32'sd0, ST_EMPTY, '0};
    issue(r, 1, f);
    while (rsp_queue.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Ran %0d requests, checked %0d results", n_sent, n_checked);
    $display("Full rejections %0d, empty removals %0d", n_full, n_empty);
    if (errors == 0 && rsp_queue.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule

/* sim.f */
rtl/hpq_pkg.sv
rtl/hpq_mem.sv
rtl/min_max_heap_priority_queue.sv
sim/testbench.sv
